// ===== hw/rtl/rlxd_pkg.sv =====
`timescale 1ns / 1ps

package rlxd_pkg;

  localparam int FRAME_BYTES = 2048;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int IN_ADDR_W   = 11;
  localparam int CMP_W       = (POS_W > IN_ADDR_W) ? POS_W : IN_ADDR_W;
  localparam int SUM_W       = POS_W + 1;

  localparam logic [7:0] KEEP_PHASE_RUN = 8'd255;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
    addr_t      raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/rlxd_frame_ram.sv =====
`timescale 1ns / 1ps

module rlxd_frame_ram (
  input  logic              clk,
  input  rlxd_pkg::ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [rlxd_pkg::FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== hw/rtl/rle_xor_frame_delta_apply.sv =====
`timescale 1ns / 1ps

// Run-length XOR delta engine over a 1 bpp frame store (FRAME_BYTES bytes).
// Input channel: in_valid / in_stall, one beat per item. mode selects a
// delta run byte, a frame byte write or a frame byte read.
// Output channel: out_valid / out_stall, exactly one result beat per item,
// held in an output register; a stalled result does not change.
// One item is worked at a time; in_stall is low only when the engine is idle.
// The next item is taken while the previous result still waits downstream.
// Path from input beat to result beat:
//   skip run, write, unused mode : straight to the result state
//   read                         : frame RAM read state, then the result state
//   flip run of L pixels         : flip state for each byte touched, flush, result,
//     one frame byte read-modify-written per cycle through the frame RAM
//     (read issued, XOR and write back in the next cycle, pipelined).
// If the result register is still full, the item waits until it drains.
// Reset: synchronous, active high. After reset the frame RAM is cleared one
// byte per cycle (all FRAME_BYTES bytes, 2048 by default) with in_stall high;
// delta position, phase and overrun flag return to their start values.

module rle_xor_frame_delta_apply (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  run_length,
  input  logic        first_of_delta,
  input  logic        last_of_delta,
  input  logic [10:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        delta_done,
  output logic        delta_ok
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FLIP,
    S_FLUSH,
    S_READ,
    S_RESULT
  } state_t;

  state_t state;

  logic [rlxd_pkg::ADDR_W-1:0] clr_addr;
  logic                        phase;
  logic [rlxd_pkg::POS_W-1:0]  byte_pos;
  logic [2:0]                  bit_pos;
  logic                        overrun;
  logic [7:0]                  remaining;
  logic                        wb_valid;
  logic [rlxd_pkg::ADDR_W-1:0] wb_addr;
  logic [7:0]                  wb_mask;
  logic                        rd_hit;
  logic [7:0]                  res_data;
  logic                        res_done;

  rlxd_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;

  logic                        accept;
  rlxd_pkg::mode_t             mode_code;
  logic [rlxd_pkg::CMP_W-1:0]  addr_ext;
  logic                        addr_hit;
  logic [rlxd_pkg::ADDR_W-1:0] addr_idx;

  logic                        phase_eff;
  logic [rlxd_pkg::POS_W-1:0]  pos_eff;
  logic [2:0]                  bit_eff;
  logic [2:0]                  frac;
  logic                        carry;
  logic [rlxd_pkg::SUM_W-1:0]  skip_sum;
  logic [rlxd_pkg::POS_W-1:0]  skip_pos;

  logic [3:0]                  avail;
  logic [3:0]                  n_bits;
  logic [8:0]                  hi_mask;
  logic [8:0]                  lo_mask;
  logic [7:0]                  chunk_mask;
  logic                        in_range;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign mode_code = rlxd_pkg::mode_t'(mode);

  assign addr_ext = rlxd_pkg::CMP_W'(address);
  assign addr_hit = addr_ext < rlxd_pkg::CMP_W'(rlxd_pkg::FRAME_BYTES);
  assign addr_idx = addr_ext[rlxd_pkg::ADDR_W-1:0];

  // start point of a run byte; a first mark restarts the delta
  assign phase_eff = first_of_delta ? 1'b0 : phase;
  assign pos_eff   = first_of_delta ? '0 : byte_pos;
  assign bit_eff   = first_of_delta ? 3'd7 : bit_pos;

  assign frac     = run_length[2:0];
  assign carry    = frac > bit_eff;
  assign skip_sum = rlxd_pkg::SUM_W'(pos_eff) + rlxd_pkg::SUM_W'(run_length[7:3])
                  + rlxd_pkg::SUM_W'(carry);
  assign skip_pos = (skip_sum > rlxd_pkg::SUM_W'(rlxd_pkg::FRAME_BYTES))
                  ? rlxd_pkg::POS_W'(rlxd_pkg::FRAME_BYTES)
                  : skip_sum[rlxd_pkg::POS_W-1:0];

  // flip chunk: pixels bit_pos downward within the current byte
  assign avail      = {1'b0, bit_pos} + 4'd1;
  assign n_bits     = (remaining < {4'd0, avail}) ? remaining[3:0] : avail;
  assign hi_mask    = (9'd1 << avail) - 9'd1;
  assign lo_mask    = (9'd1 << (avail - n_bits)) - 9'd1;
  assign chunk_mask = hi_mask[7:0] & ~lo_mask[7:0];
  assign in_range   = byte_pos < rlxd_pkg::POS_W'(rlxd_pkg::FRAME_BYTES);

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = wb_addr;
    ram_req.wdata = ram_rdata ^ wb_mask;
    ram_req.raddr = byte_pos[rlxd_pkg::ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = 8'd0;
      end
      S_IDLE: begin
        ram_req.we    = accept && (mode_code == rlxd_pkg::MODE_WRITE) && addr_hit;
        ram_req.waddr = addr_idx;
        ram_req.wdata = write_data;
        ram_req.raddr = addr_idx;
      end
      S_FLIP, S_FLUSH: begin
        ram_req.we = wb_valid;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  rlxd_frame_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      phase     <= 1'b0;
      byte_pos  <= '0;
      bit_pos   <= 3'd7;
      overrun   <= 1'b0;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + rlxd_pkg::ADDR_W'(1);
          if (clr_addr == rlxd_pkg::ADDR_W'(rlxd_pkg::FRAME_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_data <= 8'd0;
            res_done <= (mode_code == rlxd_pkg::MODE_RUN) && last_of_delta;
            rd_hit   <= addr_hit;
            case (mode_code)
              rlxd_pkg::MODE_RUN: begin
                if (first_of_delta) begin
                  overrun <= 1'b0;
                end
                phase <= (run_length != rlxd_pkg::KEEP_PHASE_RUN) ? ~phase_eff : phase_eff;
                if (phase_eff) begin
                  byte_pos  <= pos_eff;
                  bit_pos   <= bit_eff;
                  remaining <= run_length;
                  state     <= (run_length == 8'd0) ? S_RESULT : S_FLIP;
                end else begin
                  byte_pos <= skip_pos;
                  bit_pos  <= bit_eff - frac;
                  state    <= S_RESULT;
                end
              end
              rlxd_pkg::MODE_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_READ: begin
          res_data <= rd_hit ? ram_rdata : 8'd0;
          state    <= S_RESULT;
        end
        S_FLIP: begin
          wb_valid <= in_range;
          wb_addr  <= byte_pos[rlxd_pkg::ADDR_W-1:0];
          wb_mask  <= chunk_mask;
          if (!in_range) begin
            overrun <= 1'b1;
          end
          if (n_bits == avail) begin
            bit_pos <= 3'd7;
            if (in_range) begin
              byte_pos <= byte_pos + rlxd_pkg::POS_W'(1);
            end
          end else begin
            bit_pos <= bit_pos - n_bits[2:0];
          end
          remaining <= remaining - {4'd0, n_bits};
          if (remaining == {4'd0, n_bits}) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          wb_valid <= 1'b0;
          state    <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            read_data  <= res_data;
            delta_done <= res_done;
            delta_ok   <= ~overrun;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
